// File: rtl/core/fot_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fot_pkg
// Shared types and codes of the frame orientation transform.
// ----------------------------------------------------------------------------
package fot_pkg;

    localparam int PIXEL_W   = 16;
    localparam int CFG_DIM_W = 7;
    localparam int MODE_W    = 2;
    localparam int INDEX_W   = 2;
    localparam int DIM_LIMIT = (1 << CFG_DIM_W) - 1;
    localparam int PROD_W    = 2 * CFG_DIM_W + 1;

    localparam logic [INDEX_W-1:0] REG_HEIGHT = 2'd0;
    localparam logic [INDEX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [INDEX_W-1:0] REG_MODE   = 2'd2;

    localparam logic [MODE_W-1:0] MODE_MIRROR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FLIP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ROT_CW  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ROT_CCW = 2'd3;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    typedef struct packed {
        logic wr_en;
        logic addr_load;
        logic mem_rd;
        logic out_ok;
        logic out_nr;
    } cmd_t;

    typedef struct packed {
        logic frame_ready;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

// File: rtl/core/fot_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fot_ctrl
// Sequencer: accepts requests and steps a read through address, memory
// and output phases.
// ----------------------------------------------------------------------------
module fot_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic          func,
    input  wire fot_pkg::stat_t stat,
    output fot_pkg::cmd_t      cmd
);
    import fot_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_ADDR,
        ST_RD_MEM,
        ST_RD_OUT,
        ST_NR_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (func == FUNC_WRITE) begin
                        cmd.wr_en = 1'b1;
                    end else if (stat.frame_ready) begin
                        state_next = ST_RD_ADDR;
                    end else begin
                        state_next = ST_NR_OUT;
                    end
                end
            end
            ST_RD_ADDR: begin
                cmd.addr_load = 1'b1;
                state_next    = ST_RD_MEM;
            end
            ST_RD_MEM: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_RD_OUT;
            end
            ST_RD_OUT: begin
                if (stat.out_free) begin
                    cmd.out_ok = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_NR_OUT: begin
                if (stat.out_free) begin
                    cmd.out_nr = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/fot_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fot_datapath
// Frame store, configuration registers, write/read counters, source address
// generation and output register.
// ----------------------------------------------------------------------------
module fot_datapath #(
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_WIDTH  = 64,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    input  wire logic [fot_pkg::INDEX_W-1:0]   cfg_index,
    input  wire logic [fot_pkg::CFG_DIM_W-1:0] cfg_data,
    input  wire logic [fot_pkg::PIXEL_W-1:0]   pixel_in,
    input  wire fot_pkg::cmd_t                 cmd,
    output fot_pkg::stat_t                     stat,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [fot_pkg::PIXEL_W-1:0]        m_tdata,
    output logic                               m_tlast,
    output logic                               m_tuser
);
    import fot_pkg::*;

    localparam int HCAP  = (MAX_HEIGHT < DIM_LIMIT) ? MAX_HEIGHT : DIM_LIMIT;
    localparam int WCAP  = (MAX_WIDTH < DIM_LIMIT) ? MAX_WIDTH : DIM_LIMIT;
    localparam int DEPTH = HCAP * WCAP;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [CFG_DIM_W-1:0] HCAP_V = CFG_DIM_W'(HCAP);
    localparam logic [CFG_DIM_W-1:0] WCAP_V = CFG_DIM_W'(WCAP);
    localparam logic [CFG_DIM_W-1:0] ONE_V  = CFG_DIM_W'(1);

    logic [PIXEL_BITS-1:0] mem [DEPTH];

    logic [CFG_DIM_W-1:0]  height_reg;
    logic [CFG_DIM_W-1:0]  width_reg;
    logic [MODE_W-1:0]     mode_reg;
    logic [AW-1:0]         wr_addr_reg;
    logic [CFG_DIM_W-1:0]  wr_row_reg;
    logic [CFG_DIM_W-1:0]  wr_col_reg;
    logic [CFG_DIM_W-1:0]  rd_row_reg;
    logic [CFG_DIM_W-1:0]  rd_col_reg;
    logic                  ready_reg;
    logic [AW-1:0]         src_addr_reg;
    logic [PIXEL_BITS-1:0] rd_data_reg;
    logic                  out_valid_reg;
    logic [PIXEL_W-1:0]    out_pixel_reg;
    logic                  out_last_reg;
    logic                  out_status_reg;

    logic [CFG_DIM_W-1:0]  h_eff;
    logic [CFG_DIM_W-1:0]  w_eff;
    logic [CFG_DIM_W-1:0]  out_h;
    logic [CFG_DIM_W-1:0]  out_w;
    logic [CFG_DIM_W-1:0]  mul_a;
    logic [CFG_DIM_W-1:0]  add_b;
    logic [PROD_W-1:0]     src_sum;
    logic                  wr_last;
    logic                  rd_last;
    logic                  cfg_hit;

    assign h_eff = (height_reg == '0) ? ONE_V :
                   ((height_reg > HCAP_V) ? HCAP_V : height_reg);
    assign w_eff = (width_reg == '0) ? ONE_V :
                   ((width_reg > WCAP_V) ? WCAP_V : width_reg);
    assign out_h = mode_reg[1] ? w_eff : h_eff;
    assign out_w = mode_reg[1] ? h_eff : w_eff;

    assign wr_last = (wr_row_reg == h_eff - ONE_V) && (wr_col_reg == w_eff - ONE_V);
    assign rd_last = (rd_row_reg == out_h - ONE_V) && (rd_col_reg == out_w - ONE_V);

    assign cfg_hit = cfg_valid &&
                     ((cfg_index == REG_HEIGHT) || (cfg_index == REG_WIDTH) ||
                      (cfg_index == REG_MODE));

    always_comb begin
        unique case (mode_reg)
            MODE_MIRROR: begin
                mul_a = rd_row_reg;
                add_b = w_eff - ONE_V - rd_col_reg;
            end
            MODE_FLIP: begin
                mul_a = h_eff - ONE_V - rd_row_reg;
                add_b = rd_col_reg;
            end
            MODE_ROT_CW: begin
                mul_a = h_eff - ONE_V - rd_col_reg;
                add_b = rd_row_reg;
            end
            MODE_ROT_CCW: begin
                mul_a = rd_col_reg;
                add_b = w_eff - ONE_V - rd_row_reg;
            end
            default: begin
                mul_a = '0;
                add_b = '0;
            end
        endcase
    end

    assign src_sum = PROD_W'(mul_a) * PROD_W'(w_eff) + PROD_W'(add_b);

    // frame store
    always_ff @(posedge aclk) begin
        if (cmd.wr_en && !ready_reg) begin
            mem[wr_addr_reg] <= pixel_in[PIXEL_BITS-1:0];
        end
        if (cmd.mem_rd) begin
            rd_data_reg <= mem[src_addr_reg];
        end
        if (cmd.addr_load) begin
            src_addr_reg <= src_sum[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg    <= CFG_DIM_W'(64);
            width_reg     <= CFG_DIM_W'(64);
            mode_reg      <= MODE_MIRROR;
            wr_addr_reg   <= '0;
            wr_row_reg    <= '0;
            wr_col_reg    <= '0;
            rd_row_reg    <= '0;
            rd_col_reg    <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.out_ok || cmd.out_nr) begin
                out_valid_reg <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_hit) begin
                unique case (cfg_index)
                    REG_HEIGHT: height_reg <= cfg_data;
                    REG_WIDTH:  width_reg  <= cfg_data;
                    default:    mode_reg   <= cfg_data[MODE_W-1:0];
                endcase
                wr_addr_reg <= '0;
                wr_row_reg  <= '0;
                wr_col_reg  <= '0;
                rd_row_reg  <= '0;
                rd_col_reg  <= '0;
                ready_reg   <= 1'b0;
            end else if (cmd.wr_en && !ready_reg) begin
                wr_addr_reg <= wr_addr_reg + AW'(1);
                if (wr_last) begin
                    ready_reg <= 1'b1;
                end else if (wr_col_reg == w_eff - ONE_V) begin
                    wr_col_reg <= '0;
                    wr_row_reg <= wr_row_reg + ONE_V;
                end else begin
                    wr_col_reg <= wr_col_reg + ONE_V;
                end
            end else if (cmd.out_ok) begin
                if (rd_last) begin
                    wr_addr_reg <= '0;
                    wr_row_reg  <= '0;
                    wr_col_reg  <= '0;
                    rd_row_reg  <= '0;
                    rd_col_reg  <= '0;
                    ready_reg   <= 1'b0;
                end else if (rd_col_reg == out_w - ONE_V) begin
                    rd_col_reg <= '0;
                    rd_row_reg <= rd_row_reg + ONE_V;
                end else begin
                    rd_col_reg <= rd_col_reg + ONE_V;
                end
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (cmd.out_ok) begin
            out_pixel_reg  <= PIXEL_W'(rd_data_reg);
            out_last_reg   <= rd_last;
            out_status_reg <= 1'b0;
        end else if (cmd.out_nr) begin
            out_pixel_reg  <= '0;
            out_last_reg   <= 1'b0;
            out_status_reg <= 1'b1;
        end
    end

    assign stat.frame_ready = ready_reg;
    assign stat.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pixel_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

endmodule
`default_nettype wire

// File: rtl/core/frame_orientation_transform.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_orientation_transform
// Frame buffer that returns a mirrored, flipped or rotated frame.
// ----------------------------------------------------------------------------
// channel  direction  payload
// s_       in         tdata: pixel_in[15:0]; tuser: func (0 write, 1 read)
// m_       out        tdata: pixel_out[15:0]; tlast: frame_end; tuser: status
// cfg_     in         index 0 frame_height, 1 frame_width, 2 orientation_mode
//
// A write is taken in idle. A read steps through accept, source address
// multiply, frame store read and output register load; a read before the
// frame is loaded returns status 1. The output register holds a result
// while m_tready is low; the next request is taken once it is loaded.
// aresetn clears control state only; the frame store is not cleared.
// ----------------------------------------------------------------------------
module frame_orientation_transform #(
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_WIDTH  = 64,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [fot_pkg::PIXEL_W-1:0]   s_tdata,   // [15:0] pixel_in
    input  wire logic                          s_tuser,   // [0] func
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [fot_pkg::PIXEL_W-1:0]        m_tdata,   // [15:0] pixel_out
    output logic                               m_tlast,
    output logic                               m_tuser,   // [0] status
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [fot_pkg::INDEX_W-1:0]   cfg_index,
    input  wire logic [fot_pkg::CFG_DIM_W-1:0] cfg_data
);
    import fot_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    fot_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .func     (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    fot_datapath #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel_in  (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire
